>>> design/clsu_pkg.sv
// Shared types and constants for the cable lock sequencer unit.
// No dependencies; used by every module of the block.
package clsu_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WAKE_TICKS   = 2'd0,
    CFG_DRIVE_TICKS  = 2'd1,
    CFG_UNPLUG_TICKS = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned WakeW     = 8;
  localparam int unsigned CountW    = 16;

  // Register values after reset
  localparam logic [WakeW-1:0]  WakeTicksRst   = 8'd1;
  localparam logic [CountW-1:0] DriveTicksRst  = 16'd500;
  localparam logic [CountW-1:0] UnplugTicksRst = 16'd1000;

  typedef struct packed {
    logic [WakeW-1:0]  wake_ticks;
    logic [CountW-1:0] drive_ticks;
    logic [CountW-1:0] unplug_ticks;
  } cfg_t;

  typedef struct packed {
    logic pilot_high;
    logic button_high;
  } in_item_t;

  typedef struct packed {
    logic motor_awake;
    logic motor_dir;
    logic motor_drive;
    logic relay_closed;
    logic led_on;
    logic standby_req;
  } out_item_t;

endpackage

>>> design/cable_lock_sequencer_unit.sv
// Cable lock sequencer unit: top level with input and result registers.
// Input transaction to result transaction passes the input register, then the result register.
// Throughput: one tick per cycle unless output stalls; phase update is a single counter compare.
// Reset (rst_ni low, asynchronous): phase idle, tick count 0, direction 0, both stages empty,
// wake_ticks 1, drive_ticks 500, unplug_ticks 1000.
// Depends on clsu_pkg, clsu_cfg_regs and clsu_phase_fsm.
module cable_lock_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [clsu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [clsu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  clsu_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output clsu_pkg::out_item_t            out_item_o
);
  import clsu_pkg::*;

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_v_q;
  out_item_t  out_q, result;
  logic       out_v_q;
  logic       advance;

  clsu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Step the held tick when the result register can take it
  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;

  clsu_phase_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register: load each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Result register: hold until taken, refill on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

>>> design/clsu_cfg_regs.sv
// Configuration register bank of the cable lock sequencer unit.
// Depends on clsu_pkg for the register indexes and the cfg_t struct.
module clsu_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clsu_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [clsu_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output clsu_pkg::cfg_t                   cfg_o
);
  import clsu_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_ticks   <= WakeTicksRst;
      cfg_q.drive_ticks  <= DriveTicksRst;
      cfg_q.unplug_ticks <= UnplugTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WAKE_TICKS:   cfg_q.wake_ticks   <= cfg_wdata_i[WakeW-1:0];
        CFG_DRIVE_TICKS:  cfg_q.drive_ticks  <= cfg_wdata_i[CountW-1:0];
        CFG_UNPLUG_TICKS: cfg_q.unplug_ticks <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/clsu_phase_fsm.sv
// Phase sequencer: phase state, saturating tick counter and motor direction.
// Depends on clsu_pkg; produces the result of the tick being stepped.
module clsu_phase_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  clsu_pkg::in_item_t   item_i,
  input  clsu_pkg::cfg_t       cfg_i,
  output clsu_pkg::out_item_t  result_o
);
  import clsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAKE_ENG  = 3'd1,
    PH_DRIVE_ENG = 3'd2,
    PH_LOCKED    = 3'd3,
    PH_WAKE_DIS  = 3'd4,
    PH_DRIVE_DIS = 3'd5,
    PH_WAIT_LOW  = 3'd6,
    PH_WAIT_HIGH = 3'd7
  } phase_e;

  phase_e              ph_q, ph_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic                dir_q, dir_d;
  logic [CountW-1:0]   cnt_inc;
  logic                wake_done, drive_done;

  // Saturating increment and end-of-phase compares
  assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + CountW'(1);
  assign wake_done  = cnt_q >= CountW'(cfg_i.wake_ticks);
  assign drive_done = cnt_q >= cfg_i.drive_ticks;

  // Next phase for the tick in hand
  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    dir_d = dir_q;
    case (ph_q)
      PH_IDLE: begin
        if (!item_i.pilot_high) begin
          ph_d  = PH_WAKE_ENG;
          cnt_d = CountW'(1);
        end
      end
      PH_WAKE_ENG, PH_WAKE_DIS: begin
        if (wake_done) begin
          dir_d = (ph_q == PH_WAKE_ENG);
          ph_d  = (ph_q == PH_WAKE_ENG) ? PH_DRIVE_ENG : PH_DRIVE_DIS;
          cnt_d = CountW'(1);
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DRIVE_ENG, PH_DRIVE_DIS: begin
        if (drive_done) begin
          ph_d  = (ph_q == PH_DRIVE_ENG) ? PH_LOCKED : PH_WAIT_LOW;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_LOCKED: begin
        if (!item_i.button_high) begin
          ph_d  = PH_WAKE_DIS;
          cnt_d = CountW'(1);
        end
      end
      PH_WAIT_LOW: begin
        if (item_i.pilot_high) begin
          ph_d  = PH_WAIT_HIGH;
          cnt_d = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (!item_i.pilot_high) begin
          ph_d  = PH_WAIT_LOW;
          cnt_d = '0;
        end else if (cnt_inc >= cfg_i.unplug_ticks) begin
          ph_d  = PH_IDLE;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        ph_d  = PH_IDLE;
        cnt_d = '0;
      end
    endcase
  end

  // Hold state; advance only on a stepped tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cnt_q <= '0;
      dir_q <= 1'b0;
    end else if (step_i) begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      dir_q <= dir_d;
    end
  end

  // Decode outputs from the new phase
  always_comb begin
    result_o.motor_awake  = (ph_d == PH_WAKE_ENG) || (ph_d == PH_WAKE_DIS) ||
                            (ph_d == PH_DRIVE_ENG) || (ph_d == PH_DRIVE_DIS);
    result_o.motor_dir    = dir_d;
    result_o.motor_drive  = (ph_d == PH_DRIVE_ENG) || (ph_d == PH_DRIVE_DIS);
    result_o.relay_closed = (ph_d == PH_LOCKED);
    result_o.led_on       = (ph_d == PH_LOCKED);
    result_o.standby_req  = (ph_d == PH_IDLE) && item_i.pilot_high;
  end

endmodule
